// ===== sv/ssso_pkg.sv =====
// Package for the two-set store: operation and status codes, and the
// command and status structs between controller and datapath. No dependencies.
package ssso_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_DEL   = 3'd1;
    localparam logic [2:0] OP_FIND  = 3'd2;
    localparam logic [2:0] OP_INTER = 3'd3;
    localparam logic [2:0] OP_UNION = 3'd4;
    localparam logic [2:0] OP_DIFF  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOTF  = 2'd3;

    typedef struct packed {
        logic load;
        logic upd;
        logic rewind;
        logic rd_b;
        logic rd;
        logic adv;
        logic take;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       sel;
        logic       out_free;
        logic       hit;
        logic       scan_end;
        logic       pend_vld;
    } t_stat;

endpackage

// ===== sv/ssso_dp.sv =====
// Datapath of the two-set store: both element arrays, counts, parallel
// compares, scan pointer, pending element and output register. Uses ssso_pkg.
module ssso_dp #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssso_pkg::t_cmd      i_cmd,
    output ssso_pkg::t_stat     o_stat,
    input  logic [2:0]          i_op,
    input  logic                i_sel,
    input  logic signed [31:0]  i_value,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [3:0]          o_position,
    output logic signed [31:0]  o_element,
    output logic                o_element_valid,
    output logic                o_last,
    output logic [4:0]          o_size
);
    import ssso_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_BITS-1:0] r_mem [2][CAPACITY];
    logic [CW-1:0]         r_cnt [2];
    logic [2:0]            r_op;
    logic                  r_sel;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_idx;
    logic                  r_rd_b;
    logic [VALUE_BITS-1:0] r_elem;
    logic [VALUE_BITS-1:0] r_pend;
    logic                  r_pend_vld;

    logic                  r_o_valid;
    logic [1:0]            r_o_status;
    logic [3:0]            r_o_pos;
    logic [31:0]           r_o_elem;
    logic                  r_o_evld;
    logic                  r_o_last;
    logic [4:0]            r_o_size;

    logic [CW-1:0]         cnt_self;
    logic [CW-1:0]         cnt_cmp;
    logic [CAPACITY-1:0]   m_self;
    logic [CAPACITY-1:0]   m_hit;
    logic                  found;
    logic                  hit;
    logic                  full;
    logic [IW-1:0]         pos_f;
    logic [1:0]            status_u;
    logic [IW-1:0]         pos_u;
    logic [CW-1:0]         cnt_new;
    logic                  out_free;
    logic                  wr;

    assign cnt_self = r_cnt[r_sel];
    assign cnt_cmp  = r_cnt[~r_rd_b];
    assign full     = (cnt_self == CW'(CAPACITY));
    assign out_free = !r_o_valid || i_out_ready;
    assign wr       = i_cmd.upd || (i_cmd.take && r_pend_vld) || i_cmd.fin;

    always_comb begin
        pos_f = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            m_self[j] = (CW'(j) < cnt_self) && (r_mem[r_sel][j] == r_val);
            m_hit[j]  = (CW'(j) < cnt_cmp) && (r_mem[~r_rd_b][j] == r_elem);
            if (m_self[j]) begin
                pos_f = pos_f | IW'(j);
            end
        end
        found = |m_self;
        hit   = |m_hit;
    end

    always_comb begin
        status_u = ST_OK;
        pos_u    = '0;
        cnt_new  = cnt_self;
        unique case (r_op)
            OP_ADD: begin
                if (found) begin
                    status_u = ST_DUP;
                end else if (full) begin
                    status_u = ST_FULL;
                end else begin
                    cnt_new = cnt_self + CW'(1);
                end
            end
            OP_DEL: begin
                if (found) begin
                    pos_u   = pos_f;
                    cnt_new = cnt_self - CW'(1);
                end else begin
                    status_u = ST_NOTF;
                end
            end
            OP_FIND: begin
                if (found) begin
                    pos_u = pos_f;
                end else begin
                    status_u = ST_NOTF;
                end
            end
            default: begin
                status_u = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && r_op == OP_ADD && !found && !full) begin
            r_mem[r_sel][cnt_self[IW-1:0]] <= r_val;
        end else if (i_cmd.upd && r_op == OP_DEL && found) begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
                if (IW'(j) >= pos_f && CW'(j + 1) < cnt_self) begin
                    r_mem[r_sel][j] <= r_mem[r_sel][j + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0]   <= '0;
            r_cnt[1]   <= '0;
            r_idx      <= '0;
            r_rd_b     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                r_cnt[r_sel] <= cnt_new;
            end
            if (i_cmd.rewind) begin
                r_idx  <= '0;
                r_rd_b <= i_cmd.rd_b;
            end else if (i_cmd.adv) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.fin) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.take) begin
                r_pend_vld <= 1'b1;
            end
            if (wr) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_sel <= i_sel;
            r_val <= VALUE_BITS'(i_value);
        end
        if (i_cmd.rd) begin
            r_elem <= r_mem[r_rd_b][r_idx[IW-1:0]];
        end
        if (i_cmd.take) begin
            r_pend <= r_elem;
        end
        if (i_cmd.upd) begin
            r_o_status <= status_u;
            r_o_pos    <= 4'(pos_u);
            r_o_elem   <= '0;
            r_o_evld   <= 1'b0;
            r_o_last   <= 1'b1;
            r_o_size   <= 5'(cnt_new);
        end else if (wr) begin
            r_o_status <= ST_OK;
            r_o_pos    <= '0;
            r_o_elem   <= r_pend_vld ? 32'(r_pend) : 32'd0;
            r_o_evld   <= r_pend_vld;
            r_o_last   <= i_cmd.fin;
            r_o_size   <= 5'(cnt_self);
        end
    end

    assign o_stat = '{op: r_op, sel: r_sel, out_free: out_free, hit: hit,
                      scan_end: (r_idx >= r_cnt[r_rd_b]), pend_vld: r_pend_vld};

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_position      = r_o_pos;
    assign o_element       = r_o_elem;
    assign o_element_valid = r_o_evld;
    assign o_last          = r_o_last;
    assign o_size          = r_o_size;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CW'(CAPACITY) && r_cnt[1] <= CW'(CAPACITY))
        else $error("set count beyond capacity");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take && r_pend_vld |-> out_free)
        else $error("pending element pushed into a full output register");
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |-> !i_cmd.take && !i_cmd.fin && !i_cmd.rd)
        else $error("update overlaps a scan command");
`endif

endmodule

// ===== sv/ssso_ctrl.sv =====
// Controller of the two-set store: sequences single-item updates and the
// element scans of the set operations. Uses ssso_pkg.
module ssso_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output ssso_pkg::t_cmd  o_cmd,
    input  ssso_pkg::t_stat i_stat
);
    import ssso_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_phase;
    logic       n_phase;
    logic       set_op;
    logic       qual;

    assign set_op = (i_stat.op == OP_INTER) || (i_stat.op == OP_UNION) ||
                    (i_stat.op == OP_DIFF);
    assign qual   = (i_stat.op == OP_INTER) ? i_stat.hit :
                    (i_stat.op == OP_UNION && !r_phase) ? 1'b1 : !i_stat.hit;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (set_op) begin
                    o_cmd.rewind = 1'b1;
                    o_cmd.rd_b   = (i_stat.op == OP_INTER) ? i_stat.sel : ~i_stat.sel;
                    n_phase      = 1'b0;
                    n_state      = S_RD;
                end else if (i_stat.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_RD: begin
                if (i_stat.scan_end) begin
                    if (i_stat.op == OP_UNION && !r_phase) begin
                        o_cmd.rewind = 1'b1;
                        o_cmd.rd_b   = i_stat.sel;
                        n_phase      = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (!(qual && i_stat.pend_vld && !i_stat.out_free)) begin
                    o_cmd.adv  = 1'b1;
                    o_cmd.take = qual;
                    n_state    = S_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_phase   = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTHESIS
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC)
        else $error("accepted word not followed by execute");
    a_phase_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_stat.op == OP_UNION)
        else $error("second scan phase outside union");
`endif

endmodule

// ===== sv/small_set_store_with_set_ops_core.sv =====
// Top level of the two-set store with add, delete, find and set operations.
// Instantiates ssso_ctrl and ssso_dp; uses ssso_pkg.
//
//  channel  dir  tdata                                       tuser              tlast
//  s        in   value[31:0]                                 op[2:0],set_sel[3] -
//  m        out  status[1:0],position[5:2],element[37:6],    element_valid[0]   last
//                size[42:38], zero fill to 48 bits
//
// Add, delete, find: each word is accepted, then executed.
// Set operations: accept, start, then a read and a compare per scanned
// element, an end of scan and the closing word; union scans the other set,
// then the selected one, with a second end of scan before the closing word.
// Reset: synchronous, clears both counts. A stalled output holds the scan and
// the update; one input word is taken while a result waits.
module small_set_store_with_set_ops_core #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // value[31:0]
    input  logic [3:0]   i_s_tuser,   // op[2:0], set_sel[3]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,   // status, position, element, size, zero fill
    output logic [0:0]   o_m_tuser,   // element_valid[0]
    output logic         o_m_tlast
);
    import ssso_pkg::*;

    t_cmd               cmd;
    t_stat              stat;
    logic [1:0]         status;
    logic [3:0]         position;
    logic signed [31:0] element;
    logic               element_valid;
    logic [4:0]         size;

    ssso_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ssso_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_s_tuser[2:0]),
        .i_sel           (i_s_tuser[3]),
        .i_value         (i_s_tdata),
        .i_out_ready     (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_status        (status),
        .o_position      (position),
        .o_element       (element),
        .o_element_valid (element_valid),
        .o_last          (o_m_tlast),
        .o_size          (size)
    );

    assign o_m_tdata = {5'd0, size, element, position, status};
    assign o_m_tuser = element_valid;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for small_set_store_with_set_ops_core: add, delete, find
// and the streamed set operations, checked against an in-bench predictor.
// Depends on ssso_pkg and the core; needs no files or arguments.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssso_pkg::*;

    localparam int          CAPACITY    = 16;
    localparam int          POOL_SIZE   = 24;
    localparam int          RANDOM_CMDS = 350;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          HOLDOFF_AT  = 140;
    localparam int          HOLDOFF_LEN = 600;
    localparam logic [2:0]  OP_RSV6     = 3'd6;
    localparam logic [2:0]  OP_RSV7     = 3'd7;

    typedef struct packed {
        logic        hold;
        logic [2:0]  op;
        logic        sel;
        logic [31:0] value;
    } t_drv_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  position;
        logic [31:0] element;
        logic        elem_valid;
        logic        last;
        logic [4:0]  size;
    } t_res_word;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // value[31:0]
    logic [3:0]  i_s_tuser  = '0;   // op[2:0], set_sel[3]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // status[1:0], position[5:2], element[37:6], size[42:38]
    logic [0:0]  o_m_tuser;         // element_valid[0]
    logic        o_m_tlast;

    t_drv_cmd    cmd_queue[$];
    t_res_word   pending_results[$];
    logic [31:0] value_pool [POOL_SIZE];
    logic [31:0] set_mem [2][CAPACITY];
    logic [4:0]  set_cnt [2];

    int          words_in      = 0;
    int          words_offered = 0;
    int          errors        = 0;
    int          cycle_count   = 0;
    int          burst_left    = 8;
    int          gap_left      = 0;
    int          rx_mode       = 0;
    int          rx_left       = 0;
    int          holdoff_left  = 0;
    bit          holdoff_done  = 1'b0;
    t_drv_cmd    cur_cmd;
    t_res_word   want;
    t_res_word   got;
    logic        nxt_valid;

    small_set_store_with_set_ops_core #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (32)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int find_pos(input logic s, input logic [31:0] v);
        for (int i = 0; i < set_cnt[s]; i++) begin
            if (set_mem[s][i] == v) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void push_elem(input logic sel, input logic [31:0] e);
        t_res_word w;
        w            = '0;
        w.element    = e;
        w.elem_valid = 1'b1;
        w.size       = set_cnt[sel];
        pending_results.push_back(w);
    endfunction

    function automatic void apply_command(input logic [2:0] op, input logic sel,
                                          input logic [31:0] v);
        logic      oth;
        int        p;
        int        n0;
        t_res_word r;
        oth = ~sel;
        n0  = pending_results.size();
        r   = '0;
        case (op)
            OP_ADD: begin
                p = find_pos(sel, v);
                if (p >= 0) begin
                    r.status = ST_DUP;
                end else if (set_cnt[sel] >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    set_mem[sel][set_cnt[sel]] = v;
                    set_cnt[sel] = set_cnt[sel] + 5'd1;
                end
            end
            OP_DEL: begin
                p = find_pos(sel, v);
                if (p < 0) begin
                    r.status = ST_NOTF;
                end else begin
                    r.position = p[3:0];
                    for (int i = p; i < set_cnt[sel] - 1; i++) begin
                        set_mem[sel][i] = set_mem[sel][i + 1];
                    end
                    set_cnt[sel] = set_cnt[sel] - 5'd1;
                end
            end
            OP_FIND: begin
                p = find_pos(sel, v);
                if (p < 0) begin
                    r.status = ST_NOTF;
                end else begin
                    r.position = p[3:0];
                end
            end
            OP_INTER: begin
                for (int i = 0; i < set_cnt[sel]; i++) begin
                    if (find_pos(oth, set_mem[sel][i]) >= 0) begin
                        push_elem(sel, set_mem[sel][i]);
                    end
                end
            end
            OP_UNION: begin
                for (int i = 0; i < set_cnt[oth]; i++) begin
                    push_elem(sel, set_mem[oth][i]);
                end
                for (int i = 0; i < set_cnt[sel]; i++) begin
                    if (find_pos(oth, set_mem[sel][i]) < 0) begin
                        push_elem(sel, set_mem[sel][i]);
                    end
                end
            end
            OP_DIFF: begin
                for (int i = 0; i < set_cnt[oth]; i++) begin
                    if (find_pos(sel, set_mem[oth][i]) < 0) begin
                        push_elem(sel, set_mem[oth][i]);
                    end
                end
            end
            default: begin
            end
        endcase
        if (pending_results.size() == n0) begin
            r.last = 1'b1;
            r.size = set_cnt[sel];
            pending_results.push_back(r);
        end else begin
            pending_results[$].last = 1'b1;
        end
    endfunction

    function automatic void add_cmd(input logic [2:0] op, input logic sel,
                                    input logic [31:0] v);
        t_drv_cmd c;
        c.hold  = 1'b0;
        c.op    = op;
        c.sel   = sel;
        c.value = v;
        cmd_queue.push_back(c);
    endfunction

    function automatic void add_hold();
        t_drv_cmd c;
        c      = '0;
        c.hold = 1'b1;
        cmd_queue.push_back(c);
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_op();
        int w;
        w = $urandom_range(0, 99);
        if (w < 35) return OP_ADD;
        if (w < 55) return OP_DEL;
        if (w < 68) return OP_FIND;
        if (w < 76) return OP_INTER;
        if (w < 84) return OP_UNION;
        if (w < 92) return OP_DIFF;
        if (w < 96) return OP_RSV6;
        return OP_RSV7;
    endfunction

    // sample: predict on accepted input words, check accepted output words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                apply_command(i_s_tuser[2:0], i_s_tuser[3], i_s_tdata);
                words_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%b last=%b",
                             $time, o_m_tdata, o_m_tuser, o_m_tlast);
                end else begin
                    want           = pending_results.pop_front();
                    got.status     = o_m_tdata[1:0];
                    got.position   = o_m_tdata[5:2];
                    got.element    = o_m_tdata[37:6];
                    got.size       = o_m_tdata[42:38];
                    got.elem_valid = o_m_tuser[0];
                    got.last       = o_m_tlast;
                    if (got != want) begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d pos=%0d el=%h ev=%b last=%b size=%0d",
                                 $time, want.status, want.position, want.element,
                                 want.elem_valid, want.last, want.size);
                        $display("%0t:          actual st=%0d pos=%0d el=%h ev=%b last=%b size=%0d",
                                 $time, got.status, got.position, got.element,
                                 got.elem_valid, got.last, got.size);
                    end
                end
            end
        end
    end

    // drive input words in bursts; hold markers wait for the result stream to drain
    always @(negedge i_clk) begin
        nxt_valid = 1'b0;
        if (i_rst_n) begin
            if (words_in != words_offered) begin
                nxt_valid = 1'b1;
            end else if (cmd_queue.size() > 0 && cmd_queue[0].hold) begin
                if (pending_results.size() == 0) begin
                    void'(cmd_queue.pop_front());
                end
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() > 0) begin
                cur_cmd = cmd_queue.pop_front();
                i_s_tdata <= cur_cmd.value;
                i_s_tuser <= {cur_cmd.sel, cur_cmd.op};
                words_offered++;
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    burst_left = $urandom_range(30, 60);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
            end
        end
        i_s_tvalid <= nxt_valid;
    end

    // receiver stall patterns, plus one long hold-off to back up the core
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_m_tready <= 1'b0;
        end else if (!holdoff_done && words_in >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 1) == 1);
                2:       i_m_tready <= ((rx_left % 5) != 0 && (rx_left % 7) != 3);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int   kind;
        int   n;
        logic sel;
        bit   first;

        set_cnt[0] = '0;
        set_cnt[1] = '0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom();
        end

        add_cmd(OP_INTER, 1'b0, 32'h0);
        add_cmd(OP_UNION, 1'b1, 32'h0);
        add_cmd(OP_DIFF,  1'b0, 32'h0);
        add_cmd(OP_FIND,  1'b0, 32'h0);
        add_cmd(OP_DEL,   1'b1, 32'h0);
        add_cmd(OP_RSV6,  1'b0, 32'hFFFF_FFFF);
        add_cmd(OP_RSV7,  1'b1, 32'h0);
        add_cmd(OP_ADD,   1'b0, 32'h8000_0000);
        add_cmd(OP_ADD,   1'b0, 32'h7FFF_FFFF);
        add_cmd(OP_ADD,   1'b0, 32'h0);
        add_cmd(OP_ADD,   1'b0, 32'hFFFF_FFFF);
        add_cmd(OP_ADD,   1'b0, 32'hFFFF_FFFF);
        add_cmd(OP_ADD,   1'b1, 32'h7FFF_FFFF);
        add_cmd(OP_ADD,   1'b1, 32'h5);
        add_cmd(OP_FIND,  1'b0, 32'h7FFF_FFFF);
        add_cmd(OP_INTER, 1'b0, 32'h0);
        add_cmd(OP_UNION, 1'b0, 32'h0);
        add_cmd(OP_DIFF,  1'b0, 32'h0);
        add_cmd(OP_UNION, 1'b1, 32'hFFFF_FFFF);
        add_cmd(OP_DIFF,  1'b1, 32'h0);
        add_cmd(OP_DEL,   1'b0, 32'h8000_0000);
        add_cmd(OP_FIND,  1'b0, 32'hFFFF_FFFF);
        add_cmd(OP_DEL,   1'b0, 32'h0001_2345);
        add_cmd(OP_FIND,  1'b1, 32'hAAAA_AAAA);
        add_hold();

        n     = cmd_queue.size();
        first = 1'b1;
        while (cmd_queue.size() - n < RANDOM_CMDS) begin
            kind = first ? 0 : $urandom_range(0, 9);
            sel  = first ? 1'b1 : 1'($urandom_range(0, 1));
            first = 1'b0;
            if (kind < 2) begin
                repeat ($urandom_range(16, 22)) begin
                    add_cmd(OP_ADD, sel,
                            $urandom_range(0, 1) ? $urandom() : pick_value());
                end
                add_cmd(pick_op(), sel, pick_value());
                add_cmd(OP_UNION, ~sel, $urandom());
            end else if (kind < 3) begin
                repeat ($urandom_range(6, 18)) begin
                    add_cmd(OP_ADD, sel, $urandom());
                end
                add_cmd(OP_UNION, sel, $urandom());
                add_cmd(OP_INTER, ~sel, $urandom());
                add_cmd(OP_DIFF, sel, $urandom());
            end else if (kind < 4) begin
                repeat ($urandom_range(8, 20)) begin
                    add_cmd($urandom_range(0, 3) == 0 ? OP_FIND : OP_DEL, sel,
                            value_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end
                add_cmd(OP_DIFF, ~sel, $urandom());
            end else begin
                repeat ($urandom_range(10, 30)) begin
                    add_cmd(pick_op(), 1'($urandom_range(0, 1)), pick_value());
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                add_hold();
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || words_in != words_offered) begin
            @(posedge i_clk);
        end
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
